>>> rtl/swcf_pkg.sv
// shared types and constants for the sliding window curve feature block
// no dependencies
package swcf_pkg;

  // feature kinds carried in the result beat
  localparam logic [1:0] KIND_DELTA = 2'd0;
  localparam logic [1:0] KIND_NORM  = 2'd1;
  localparam logic [1:0] KIND_SQR   = 2'd2;

  // beat layout
  localparam int SAMPLE_W = 16;
  localparam int FEAT_W   = 17;
  localparam int POS_W    = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 7;

  // serial divider: one quotient bit per cycle
  localparam int QUO_W = 17;
  localparam int CNT_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELTA,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NORM_EMIT,
    ST_SQ_MUL,
    ST_SQ_EMIT
  } state_t;

  // divider handshake with the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/sliding_window_curve_features_core.sv
// Once the window is full a sample gives 3*(WINDOW-1) result beats: the deltas, then for each
// deviation a divider run and its normal, then the squares. A new sample is taken only in
// idle, once the last square of the previous one has been emitted; the bit-serial divider
// takes 17 steps per normal. Samples that do not fill the window give no results, and the
// block stays ready for the next sample. Output stalls hold the sequencer.
// Reset clears the window to zero, the fill count and the sequencer; no result is pending.
// top level: window line, scan/delta/normal/square sequencer, output register
// depends on swcf_pkg and swcf_divider
module sliding_window_curve_features_core #(
  parameter int WINDOW = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_value
  input  logic [0:0]  in_tuser,   // [0] first_of_curve
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] feature_value, rest zero
  output logic [6:0]  out_tuser,  // [1:0] feature_kind, [6:2] window_position
  output logic        out_tlast   // last_feature
);

  localparam int K      = WINDOW - 1;
  localparam int CENTRE = WINDOW / 2;
  localparam int IW     = $clog2(WINDOW + 1);

  swcf_pkg::state_t state_r, state_nxt;

  logic signed [15:0] win_r  [WINDOW];
  logic signed [15:0] work_r [WINDOW];
  logic signed [16:0] devl_r [K];
  logic signed [15:0] ql_r   [K];
  logic signed [15:0] centre_r;
  logic signed [16:0] prev_r;
  logic [15:0]        max_r;
  logic [IW-1:0]      fill_r, fill_nxt;
  logic [IW-1:0]      idx_r;
  logic [31:0]        prod_r;

  logic               out_valid_r;
  logic signed [16:0] out_val_r;
  logic [1:0]         out_kind_r;
  logic [4:0]         out_pos_r;
  logic               out_last_r;

  logic               accept, go, can_emit, idx_end;
  logic signed [16:0] scan_dev;
  logic [15:0]        scan_abs;
  logic signed [17:0] dsum;
  logic signed [16:0] delta_val;
  logic [31:0]        rnd;
  logic signed [18:0] sq_full;
  logic signed [16:0] sq_val;

  // sequencer outputs
  logic               emit, adv, div_start;
  logic signed [16:0] emit_val;
  logic [1:0]         emit_kind;
  logic               emit_last;

  swcf_pkg::div_status_t div_st;
  logic signed [15:0]    div_q;

  swcf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dev      (devl_r[0]),
    .max_abs  (max_r),
    .status   (div_st),
    .quotient (div_q)
  );

  assign in_tready = (state_r == swcf_pkg::ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign can_emit  = !out_valid_r || out_tready;

  // fill count restarts at one on first_of_curve and saturates at the window length
  always_comb begin
    if (in_tuser[0]) fill_nxt = IW'(1);
    else if (fill_r < IW'(WINDOW)) fill_nxt = fill_r + 1'b1;
    else fill_nxt = fill_r;
  end
  assign go = (fill_nxt == IW'(WINDOW));

  assign idx_end = (state_r == swcf_pkg::ST_SCAN) ? (idx_r == IW'(WINDOW - 1))
                                                  : (idx_r == IW'(K - 1));

  // scan arithmetic
  assign scan_dev = 17'(work_r[0]) - 17'(centre_r);
  assign scan_abs = scan_dev[16] ? 16'(-scan_dev) : 16'(scan_dev);

  // smoothed delta: one-sided at the ends, halved central difference inside
  always_comb begin
    if (idx_r == '0) dsum = 18'(devl_r[1]) - 18'(devl_r[0]);
    else if (idx_r == IW'(K - 1)) dsum = 18'(devl_r[0]) - 18'(prev_r);
    else dsum = 18'(devl_r[1]) - 18'(prev_r);
    if (idx_r == '0 || idx_r == IW'(K - 1)) delta_val = 17'(dsum);
    else if (dsum[17]) delta_val = 17'(dsum >>> 1);
    else delta_val = 17'((dsum + 18'sd1) >>> 1);
  end

  // twice squared minus one
  assign rnd     = prod_r + 32'd8192;
  assign sq_full = $signed({1'b0, rnd[31:14]}) - 19'sd32768;
  assign sq_val  = (sq_full > 19'sd32767) ? 17'sd32767 : 17'(sq_full);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swcf_pkg::ST_IDLE:      if (accept && go) state_nxt = swcf_pkg::ST_SCAN;
      swcf_pkg::ST_SCAN:      if (idx_end) state_nxt = swcf_pkg::ST_DELTA;
      swcf_pkg::ST_DELTA:     if (can_emit && idx_end) state_nxt = swcf_pkg::ST_DIV_START;
      swcf_pkg::ST_DIV_START: state_nxt = swcf_pkg::ST_DIV_WAIT;
      swcf_pkg::ST_DIV_WAIT:  if (div_st.done) state_nxt = swcf_pkg::ST_NORM_EMIT;
      swcf_pkg::ST_NORM_EMIT: if (can_emit) begin
        state_nxt = idx_end ? swcf_pkg::ST_SQ_MUL : swcf_pkg::ST_DIV_START;
      end
      swcf_pkg::ST_SQ_MUL:    state_nxt = swcf_pkg::ST_SQ_EMIT;
      swcf_pkg::ST_SQ_EMIT:   if (can_emit) begin
        state_nxt = idx_end ? swcf_pkg::ST_IDLE : swcf_pkg::ST_SQ_MUL;
      end
      default:                state_nxt = swcf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit      = 1'b0;
    adv       = 1'b0;
    div_start = 1'b0;
    emit_val  = delta_val;
    emit_kind = swcf_pkg::KIND_DELTA;
    emit_last = 1'b0;
    unique case (state_r)
      swcf_pkg::ST_SCAN:      adv = 1'b1;
      swcf_pkg::ST_DELTA: begin
        emit = can_emit;
        adv  = can_emit;
      end
      swcf_pkg::ST_DIV_START: div_start = 1'b1;
      swcf_pkg::ST_NORM_EMIT: begin
        emit      = can_emit;
        adv       = can_emit;
        emit_val  = 17'(div_q);
        emit_kind = swcf_pkg::KIND_NORM;
      end
      swcf_pkg::ST_SQ_EMIT: begin
        emit      = can_emit;
        adv       = can_emit;
        emit_val  = sq_val;
        emit_kind = swcf_pkg::KIND_SQR;
        emit_last = idx_end;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swcf_pkg::ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit | (out_valid_r & ~out_tready);
      if (accept) fill_r <= fill_nxt;
      if (accept || (adv && idx_end)) idx_r <= '0;
      else if (adv) idx_r <= idx_r + 1'b1;
    end
  end

  // window line, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WINDOW; j++) win_r[j] <= '0;
    end else if (accept) begin
      for (int j = 0; j < WINDOW - 1; j++) win_r[j] <= win_r[j + 1];
      win_r[WINDOW - 1] <= $signed(in_tdata);
    end
  end

  // working copies: scan line, deviation ring, normal line
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < WINDOW - 1; j++) work_r[j] <= win_r[j + 1];
      work_r[WINDOW - 1] <= $signed(in_tdata);
      centre_r <= win_r[CENTRE + 1];
      max_r    <= 16'd1;
    end
    if (state_r == swcf_pkg::ST_SCAN) begin
      for (int j = 0; j < WINDOW - 1; j++) work_r[j] <= work_r[j + 1];
      if (scan_abs > max_r) max_r <= scan_abs;
      if (idx_r != IW'(CENTRE)) begin
        for (int j = 0; j < K - 1; j++) devl_r[j] <= devl_r[j + 1];
        devl_r[K - 1] <= scan_dev;
      end
    end
    if (adv && (state_r == swcf_pkg::ST_DELTA || state_r == swcf_pkg::ST_NORM_EMIT)) begin
      for (int j = 0; j < K - 1; j++) devl_r[j] <= devl_r[j + 1];
      devl_r[K - 1] <= devl_r[0];
      prev_r <= devl_r[0];
    end
    if (adv && state_r == swcf_pkg::ST_NORM_EMIT) begin
      for (int j = 0; j < K - 1; j++) ql_r[j] <= ql_r[j + 1];
      ql_r[K - 1] <= div_q;
    end
    if (adv && state_r == swcf_pkg::ST_SQ_EMIT) begin
      for (int j = 0; j < K - 1; j++) ql_r[j] <= ql_r[j + 1];
      ql_r[K - 1] <= ql_r[0];
    end
    if (state_r == swcf_pkg::ST_SQ_MUL) prod_r <= 32'(ql_r[0] * ql_r[0]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_val_r  <= emit_val;
      out_kind_r <= emit_kind;
      out_pos_r  <= 5'(idx_r);
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_val_r};
  assign out_tuser  = {out_pos_r, out_kind_r};
  assign out_tlast  = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("result written over a beat not yet taken");

  a_last_sqr: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |-> (emit_kind == swcf_pkg::KIND_SQR && idx_r == IW'(K - 1)))
    else $error("last flag on a result other than the final square");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= IW'(WINDOW))
    else $error("fill count beyond window length");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

endmodule

>>> rtl/swcf_divider.sv
// bit-serial restoring divider producing the saturated q1.15 normal
// depends on swcf_pkg
module swcf_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [16:0]  dev,
  input  logic [15:0]         max_abs,
  output swcf_pkg::div_status_t status,
  output logic signed [15:0]  quotient
);

  logic [15:0]              rem_r, rem_nxt;
  logic [16:0]              num_r, num_nxt;
  logic [swcf_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [swcf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic                     neg_r, neg_nxt;
  logic [15:0]              den_r, den_nxt;
  logic [16:0]              abs_dev;
  logic [31:0]              numer;
  logic [16:0]              trial;
  logic                     fits;

  // numerator is |dev| * 32768 plus half the divisor for rounding
  assign abs_dev = dev[16] ? 17'(-dev) : 17'(dev);
  assign numer   = {abs_dev[16:0], 15'd0} + {17'd0, max_abs[15:1]};
  assign trial   = {rem_r, num_r[16]};
  assign fits    = (trial >= {1'b0, den_r});

  // one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    if (start) begin
      rem_nxt  = {1'b0, numer[31:17]};
      num_nxt  = numer[16:0];
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = dev[16];
      den_nxt  = max_abs;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      num_nxt = {num_r[15:0], 1'b0};
      quo_nxt = {quo_r[swcf_pkg::QUO_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == swcf_pkg::CNT_W'(swcf_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
  end

  // sign the magnitude, saturating positive results
  always_comb begin
    if (neg_r) quotient = 16'(-quo_r);
    else if (quo_r > 17'd32767) quotient = 16'sd32767;
    else quotient = 16'(quo_r);
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule
